// ===== rtl/rcpb_pkg.sv =====
// Package for the random cycle permutation builder.
// Holds the sequencer state type, request types, register indexes and
// reset constants, and the xorshift step. No dependencies.
`default_nettype none
package rcpb_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned SeedW  = 64;
  localparam int unsigned IdxW   = 10;

  localparam logic [CountW-1:0] CountReset = 11'd1024;
  localparam logic [SeedW-1:0]  SeedReset  = 64'd2305843008139952128;

  typedef enum logic {
    REG_ENTRY_COUNT = 1'b0,
    REG_PRNG_SEED   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    REQ_BUILD  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_GEN,
    S_MOD,
    S_RD_A,
    S_RD_B,
    S_WR_A,
    S_WR_B,
    S_LNK_RD,
    S_LNK_WR,
    S_LNK_END,
    S_LRESP
  } state_e;

  function automatic logic [SeedW-1:0] xorshift(input logic [SeedW-1:0] s);
    logic [SeedW-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 15);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/random_cycle_permutation_builder_top.sv =====
// Top level of the random cycle permutation builder: sequencer, registers, stores.
// Depends on rcpb_pkg, rcpb_ram and rcpb_mod_unit.
//
// A build (req_type 0) reloads the xorshift generator from the seed register,
// writes the identity into the shuffle store, shuffles it and links the entries
// into one cycle; each shuffle step waits for the bit-serial remainder unit, and
// all steps share the single store port. A lookup reads the successor table and
// answers from S_LRESP, a flagged lookup answers straight from idle. The block
// takes one transaction at a time and stalls input until the result is taken.
`default_nettype none
module random_cycle_permutation_builder_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [9:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [9:0]  successor_o,
  output logic             build_done_o,
  output logic             index_error_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (CW > rcpb_pkg::CountW) ? CW : rcpb_pkg::CountW;
  localparam int unsigned LW = CW + rcpb_pkg::IdxW;

  rcpb_pkg::state_e state_q, state_d;

  logic [rcpb_pkg::CountW-1:0] cnt_reg_q;
  logic [rcpb_pkg::SeedW-1:0]  seed_q;
  logic [rcpb_pkg::SeedW-1:0]  gen_q, gen_d;
  logic [CW-1:0]               n_q, n_d;
  logic [CW-1:0]               i_q, i_d;
  logic [CW-1:0]               pos_q, pos_d;
  logic [IW-1:0]               a_q, a_d;
  logic [IW-1:0]               first_q, first_d;
  logic [IW-1:0]               prev_q, prev_d;
  logic                        built_q, built_d;
  logic [CW-1:0]               bcnt_q, bcnt_d;
  logic                        ov_q, ov_d;
  logic [9:0]                  succ_q, succ_d;
  logic                        bd_q, bd_d;
  logic                        ie_q, ie_d;

  logic                        in_acc;
  logic                        last_i;
  logic [NW-1:0]               cnt_ext;
  logic [CW-1:0]               n_clamp;
  logic [LW-1:0]               idx_wide;
  logic [LW-1:0]               bcnt_wide;
  logic                        idx_bad;
  logic [IW+9:0]               idx_addr_ext;
  logic [IW+9:0]               succ_ext;

  logic                        st_we, sc_we;
  logic [IW-1:0]               st_addr, sc_addr;
  logic [IW-1:0]               st_wdata, sc_wdata;
  logic [IW-1:0]               st_rdata, sc_rdata;

  logic                        mod_start;
  logic                        mod_done;
  logic [CW-1:0]               mod_rem;
  logic [CW-1:0]               mod_dsr;

  assign in_stall_o = (state_q != rcpb_pkg::S_IDLE) || ov_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_i     = (i_q + 1'b1) == n_q;

  assign cnt_ext = NW'(cnt_reg_q);
  always_comb begin
    if (cnt_reg_q == '0) begin
      n_clamp = CW'(1);
    end else if (cnt_ext > NW'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = cnt_ext[CW-1:0];
    end
  end

  assign idx_wide     = LW'(entry_index_i);
  assign bcnt_wide    = LW'(bcnt_q);
  assign idx_bad      = !built_q || (idx_wide >= bcnt_wide);
  assign idx_addr_ext = {{IW{1'b0}}, entry_index_i};
  assign succ_ext     = {10'd0, sc_rdata};
  assign mod_dsr      = n_q - i_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcpb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == rcpb_pkg::REQ_BUILD) begin
            state_d = rcpb_pkg::S_INIT;
          end else if (!idx_bad) begin
            state_d = rcpb_pkg::S_LRESP;
          end
        end
      end
      rcpb_pkg::S_INIT:    if (last_i) state_d = rcpb_pkg::S_GEN;
      rcpb_pkg::S_GEN:     state_d = rcpb_pkg::S_MOD;
      rcpb_pkg::S_MOD:     if (mod_done) state_d = rcpb_pkg::S_RD_A;
      rcpb_pkg::S_RD_A:    state_d = rcpb_pkg::S_RD_B;
      rcpb_pkg::S_RD_B:    state_d = rcpb_pkg::S_WR_A;
      rcpb_pkg::S_WR_A:    state_d = rcpb_pkg::S_WR_B;
      rcpb_pkg::S_WR_B:    state_d = last_i ? rcpb_pkg::S_LNK_RD : rcpb_pkg::S_GEN;
      rcpb_pkg::S_LNK_RD:  state_d = rcpb_pkg::S_LNK_WR;
      rcpb_pkg::S_LNK_WR:  state_d = last_i ? rcpb_pkg::S_LNK_END : rcpb_pkg::S_LNK_RD;
      rcpb_pkg::S_LNK_END: state_d = rcpb_pkg::S_IDLE;
      rcpb_pkg::S_LRESP:   state_d = rcpb_pkg::S_IDLE;
      default:             state_d = rcpb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    gen_d     = gen_q;
    n_d       = n_q;
    i_d       = i_q;
    pos_d     = pos_q;
    a_d       = a_q;
    first_d   = first_q;
    prev_d    = prev_q;
    built_d   = built_q;
    bcnt_d    = bcnt_q;
    ov_d      = ov_q && out_stall_i;
    succ_d    = succ_q;
    bd_d      = bd_q;
    ie_d      = ie_q;
    st_we     = 1'b0;
    st_addr   = i_q[IW-1:0];
    st_wdata  = i_q[IW-1:0];
    sc_we     = 1'b0;
    sc_addr   = idx_addr_ext[IW-1:0];
    sc_wdata  = st_rdata;
    mod_start = 1'b0;
    unique case (state_q)
      rcpb_pkg::S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == rcpb_pkg::REQ_BUILD) begin
            gen_d = seed_q;
            n_d   = n_clamp;
            i_d   = '0;
          end else if (idx_bad) begin
            ov_d   = 1'b1;
            succ_d = '0;
            bd_d   = 1'b0;
            ie_d   = 1'b1;
          end
        end
      end
      rcpb_pkg::S_INIT: begin
        st_we = 1'b1;
        i_d   = last_i ? '0 : i_q + 1'b1;
      end
      rcpb_pkg::S_GEN: begin
        gen_d     = rcpb_pkg::xorshift(gen_q);
        mod_start = 1'b1;
      end
      rcpb_pkg::S_MOD: begin
        pos_d = i_q + mod_rem;
      end
      rcpb_pkg::S_RD_A: begin
        st_addr = i_q[IW-1:0];
      end
      rcpb_pkg::S_RD_B: begin
        st_addr = pos_q[IW-1:0];
        a_d     = st_rdata;
      end
      rcpb_pkg::S_WR_A: begin
        st_we    = 1'b1;
        st_addr  = i_q[IW-1:0];
        st_wdata = st_rdata;
      end
      rcpb_pkg::S_WR_B: begin
        st_we    = 1'b1;
        st_addr  = pos_q[IW-1:0];
        st_wdata = a_q;
        i_d      = last_i ? '0 : i_q + 1'b1;
      end
      rcpb_pkg::S_LNK_RD: begin
        st_addr = i_q[IW-1:0];
      end
      rcpb_pkg::S_LNK_WR: begin
        if (i_q == '0) begin
          first_d = st_rdata;
        end else begin
          sc_we    = 1'b1;
          sc_addr  = prev_q;
          sc_wdata = st_rdata;
        end
        prev_d = st_rdata;
        i_d    = i_q + 1'b1;
      end
      rcpb_pkg::S_LNK_END: begin
        sc_we    = 1'b1;
        sc_addr  = prev_q;
        sc_wdata = first_q;
        built_d  = 1'b1;
        bcnt_d   = n_q;
        ov_d     = 1'b1;
        succ_d   = '0;
        bd_d     = 1'b1;
        ie_d     = 1'b0;
      end
      rcpb_pkg::S_LRESP: begin
        ov_d   = 1'b1;
        succ_d = succ_ext[9:0];
        bd_d   = 1'b0;
        ie_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rcpb_pkg::S_IDLE;
      cnt_reg_q <= rcpb_pkg::CountReset;
      seed_q    <= rcpb_pkg::SeedReset;
      built_q   <= 1'b0;
      bcnt_q    <= '0;
      ov_q      <= 1'b0;
      i_q       <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      bcnt_q  <= bcnt_d;
      ov_q    <= ov_d;
      i_q     <= i_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rcpb_pkg::REG_ENTRY_COUNT: cnt_reg_q <= cfg_wdata_i[rcpb_pkg::CountW-1:0];
          rcpb_pkg::REG_PRNG_SEED:   seed_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q   <= gen_d;
    n_q     <= n_d;
    pos_q   <= pos_d;
    a_q     <= a_d;
    first_q <= first_d;
    prev_q  <= prev_d;
    succ_q  <= succ_d;
    bd_q    <= bd_d;
    ie_q    <= ie_d;
  end

  rcpb_mod_unit #(
    .DivW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (gen_d),
    .divisor_i  (mod_dsr),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  rcpb_ram #(
    .Width (IW),
    .Depth (TABLE_DEPTH)
  ) u_shuffle_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  rcpb_ram #(
    .Width (IW),
    .Depth (TABLE_DEPTH)
  ) u_successor_table (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .addr_i  (sc_addr),
    .wdata_i (sc_wdata),
    .rdata_o (sc_rdata)
  );

  assign out_valid_o   = ov_q;
  assign successor_o   = succ_q;
  assign build_done_o  = bd_q;
  assign index_error_o = ie_q;

endmodule
`default_nettype wire

// ===== rtl/rcpb_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rcpb_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/rcpb_mod_unit.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor.
// One dividend bit per cycle. Depends on rcpb_pkg.
`default_nettype none
module rcpb_mod_unit #(
  parameter int unsigned DivW = 11
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rcpb_pkg::SeedW-1:0]    dividend_i,
  input  wire logic [DivW-1:0]               divisor_i,
  output logic                               done_o,
  output logic      [DivW-1:0]               rem_o
);

  localparam int unsigned CntW = $clog2(rcpb_pkg::SeedW);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [rcpb_pkg::SeedW-1:0] div_q, div_d;
  logic [DivW-1:0]            dsr_q, dsr_d;
  logic [DivW-1:0]            rem_q, rem_d;
  logic [DivW:0]              trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, div_q[rcpb_pkg::SeedW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[DivW-1:0];
      div_d = div_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== tb/sv/random_cycle_permutation_builder_top_tb.sv =====
// Self-checking testbench for random_cycle_permutation_builder_top.
// Predicts each result with its own shuffle model; depends on rcpb_pkg and the DUT.
`timescale 1ns / 1ps
module random_cycle_permutation_builder_top_tb;

  localparam int Depth = 1024;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    rcpb_pkg::req_type_e kind;
    logic [9:0]          idx;
  } request_t;

  typedef struct {
    logic [9:0] succ;
    logic       done;
    logic       err;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [9:0]  entry_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  successor_o;
  logic        build_done_o;
  logic        index_error_o;

  random_cycle_permutation_builder_top u_dut (.*);

  always #1 clk_i = ~clk_i;

  request_t   pending_reqs[$];
  answer_t    expected_answers[$];
  request_t   cur_req;
  logic [10:0] count_reg = rcpb_pkg::CountReset;
  logic [63:0] seed_reg  = rcpb_pkg::SeedReset;
  logic [9:0] order_tbl[Depth];
  logic [9:0] next_tbl[Depth];
  logic       table_built = 1'b0;
  int         table_n = 0;
  int         send_idle_pct = 15;
  int         recv_idle_pct = 49;
  bit         hold_request = 1'b0;
  int         hold_left = 0;
  int         mismatches = 0;
  longint     cycles = 0;

  function automatic int clamp_count(logic [10:0] c);
    if (c == 0) return 1;
    if (c > Depth) return Depth;
    return int'(c);
  endfunction

  function automatic logic [63:0] step_gen(logic [63:0] s);
    s = s ^ (s << 13);
    s = s ^ (s >> 15);
    return s ^ (s << 5);
  endfunction

  task automatic predict_answer(request_t r);
    answer_t     a;
    logic [63:0] g;
    logic [9:0]  t;
    int          n;
    int          p;
    a = '{succ: '0, done: 1'b0, err: 1'b0};
    if (r.kind == rcpb_pkg::REQ_BUILD) begin
      n = clamp_count(count_reg);
      g = seed_reg;
      for (int i = 0; i < n; i++) order_tbl[i] = i[9:0];
      for (int i = 0; i < n; i++) begin
        g = step_gen(g);
        p = i + int'(g % 64'(n - i));
        t = order_tbl[i];
        order_tbl[i] = order_tbl[p];
        order_tbl[p] = t;
      end
      for (int i = 0; i < n; i++)
        next_tbl[order_tbl[i]] = order_tbl[(i + 1 == n) ? 0 : i + 1];
      table_n = n;
      table_built = 1'b1;
      a.done = 1'b1;
    end else if (!table_built || int'(r.idx) >= table_n) begin
      a.err = 1'b1;
    end else begin
      a.succ = next_tbl[r.idx];
    end
    expected_answers.push_back(a);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_answer(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= cur_req.kind;
          entry_index_i <= cur_req.idx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: succ %0d", successor_o);
      end else begin
        e = expected_answers.pop_front();
        if (successor_o !== e.succ || build_done_o !== e.done || index_error_o !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp succ %0d done %0b err %0b, got succ %0d done %0b err %0b",
                     e.succ, e.done, e.err, successor_o, build_done_o, index_error_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(rcpb_pkg::reg_idx_e r, logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == rcpb_pkg::REG_ENTRY_COUNT) count_reg = v[10:0];
    else seed_reg = v;
  endtask

  task automatic queue_req(rcpb_pkg::req_type_e k, int i);
    request_t r;
    r.kind = k;
    r.idx = i[9:0];
    pending_reqs.push_back(r);
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1023);
    queue_req(rcpb_pkg::REQ_BUILD, 1023);
    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1023);
    queue_req(rcpb_pkg::REQ_LOOKUP, 341);
    queue_req(rcpb_pkg::REQ_LOOKUP, 682);
    drain();
    write_reg(rcpb_pkg::REG_ENTRY_COUNT, 64'd0);
    write_reg(rcpb_pkg::REG_PRNG_SEED, 64'd0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 700);
    queue_req(rcpb_pkg::REQ_BUILD, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1);
    drain();
    write_reg(rcpb_pkg::REG_ENTRY_COUNT, 64'd1);
    write_reg(rcpb_pkg::REG_PRNG_SEED, '1);
    queue_req(rcpb_pkg::REQ_BUILD, 1023);
    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1);
    drain();
    write_reg(rcpb_pkg::REG_ENTRY_COUNT, 64'd2047);
    write_reg(rcpb_pkg::REG_PRNG_SEED, {$urandom, $urandom});
    queue_req(rcpb_pkg::REQ_BUILD, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1023);
    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    drain();
    write_reg(rcpb_pkg::REG_ENTRY_COUNT, 64'd2);
    queue_req(rcpb_pkg::REQ_BUILD, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 0);
    queue_req(rcpb_pkg::REQ_LOOKUP, 1);
    queue_req(rcpb_pkg::REQ_LOOKUP, 2);
    drain();

    for (int seg = 0; seg < 30; seg++) begin
      if (seg == 10) begin
        send_idle_pct = 49;
        recv_idle_pct = 15;
      end else if (seg == 20) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(rcpb_pkg::REG_ENTRY_COUNT, ($urandom_range(5) == 0) ? $urandom_range(25, 64)
                                                                    : $urandom_range(1, 24));
      write_reg(rcpb_pkg::REG_PRNG_SEED, {$urandom, $urandom});
      n = clamp_count(count_reg);
      if (seg == 5 || seg == 15) hold_request = 1'b1;
      if ($urandom_range(9) < 7) queue_req(rcpb_pkg::REQ_BUILD, $urandom_range(1023));
      for (int k = 0; k < 43; k++) begin
        pick = $urandom_range(99);
        if (pick < 8) queue_req(rcpb_pkg::REQ_BUILD, $urandom_range(1023));
        else if (pick < 75) queue_req(rcpb_pkg::REQ_LOOKUP, $urandom_range(n - 1));
        else queue_req(rcpb_pkg::REQ_LOOKUP, $urandom_range(1023));
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
